// ===== src/bsf_pkg.sv =====
package bsf_pkg;

  localparam int VAL_W  = 17;
  localparam int FRAC_W = 16;
  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

  localparam int NUM_BUCKETS_DEF  = 10;
  localparam int BUCKET_DEPTH_DEF = 16;
  localparam int MAX_ITEMS_DEF    = 64;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHIFT = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_t;

endpackage

// ===== src/bucket_sort_fraction_core.sv =====
// Insertion: an empty bucket or a dropped word is handled straight from idle; otherwise
// the last entry is read, each larger entry shifts up one place and the word is written in;
// one store read and write per cycle. Emission after a last word: each result is read in
// the scan state, waits on the store read register, then loads the output register; an
// output stall holds the scan, and empty buckets are passed over.
// Reset (synchronous, rst_n low) clears fills, counts and the drop flag; the store is not cleared.
module bucket_sort_fraction_core
  import bsf_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
  parameter int MAX_ITEMS    = MAX_ITEMS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAL_W-1:0] in_value,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_sorted_value,
  output logic             out_final_res,
  output logic             out_dropped
);

  localparam int BW        = $clog2(NUM_BUCKETS);
  localparam int KW        = $clog2(BUCKET_DEPTH + 1);
  localparam int STORE_CNT = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW        = (STORE_CNT > 1) ? $clog2(STORE_CNT) : 1;
  localparam int CW        = $clog2(MAX_ITEMS + 1);

  state_t state_r, state_nxt;

  logic [VAL_W-1:0] store_mem [STORE_CNT];
  logic [VAL_W-1:0] rdata_r;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata;

  logic [KW-1:0]    fill_r [NUM_BUCKETS];
  logic [CW-1:0]    total_r;
  logic             ovf_r;

  logic [VAL_W-1:0] v_r;
  logic             last_r;
  logic [BW-1:0]    b_r;
  logic [KW-1:0]    n_r;
  logic [AW-1:0]    base_r;
  logic [KW-1:0]    k_r;

  logic [BW-1:0]    eb_r;
  logic [KW-1:0]    j_r;
  logic [CW-1:0]    cnt_r;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_final_r;
  logic             out_dropped_r;

  logic [VAL_W-1:0] in_v_sat;
  logic [BW-1:0]    in_bucket;
  logic             in_fire;
  logic [BW-1:0]    fill_idx;
  logic [KW-1:0]    fill_cur;
  logic             in_drop;
  logic [AW-1:0]    in_base;
  logic             scan_hit;
  logic             out_free;
  logic             ins_done;
  logic [BW-1:0]    ins_b;
  logic [KW-1:0]    ins_n;
  logic             set_clear;

  bsf_bucket_idx #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_bucket_idx (
    .value (in_value),
    .v_sat (in_v_sat),
    .bucket(in_bucket)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // one fill read port: the incoming bucket while idle, the walk bucket otherwise
  assign fill_idx = (state_r == ST_IDLE) ? in_bucket : eb_r;
  assign fill_cur = fill_r[fill_idx];
  assign in_drop  = (fill_cur >= KW'(BUCKET_DEPTH)) || (total_r >= CW'(MAX_ITEMS));
  assign in_base  = AW'(in_bucket) * AW'(BUCKET_DEPTH);
  assign scan_hit = (j_r < fill_cur);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = base_r + AW'(k_r);
    wdata     = v_r;
    raddr     = '0;
    ins_done  = 1'b0;
    ins_b     = b_r;
    ins_n     = n_r + KW'(1);
    set_clear = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ins_b = in_bucket;
        ins_n = fill_cur + KW'(1);
        if (in_fire) begin
          if (in_drop) begin
            state_nxt = in_last ? ST_SCAN : ST_IDLE;
          end else if (fill_cur == '0) begin
            we        = 1'b1;
            waddr     = in_base;
            wdata     = in_v_sat;
            ins_done  = 1'b1;
            state_nxt = in_last ? ST_SCAN : ST_IDLE;
          end else begin
            re        = 1'b1;
            raddr     = in_base + AW'(fill_cur) - AW'(1);
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // read of k-2 and write of k never hit the same entry
        we = 1'b1;
        if (rdata_r > v_r) begin
          wdata = rdata_r;
          if (k_r == KW'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            re    = 1'b1;
            raddr = base_r + AW'(k_r) - AW'(2);
          end
        end else begin
          ins_done  = 1'b1;
          state_nxt = last_r ? ST_SCAN : ST_IDLE;
        end
      end
      ST_PLACE: begin
        we        = 1'b1;
        waddr     = base_r;
        ins_done  = 1'b1;
        state_nxt = last_r ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          if (out_free) begin
            re        = 1'b1;
            raddr     = AW'(eb_r) * AW'(BUCKET_DEPTH) + AW'(j_r);
            state_nxt = ST_WAIT;
          end
        end else if (eb_r == BW'(NUM_BUCKETS - 1)) begin
          set_clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_SCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      v_r    <= in_v_sat;
      last_r <= in_last;
      b_r    <= in_bucket;
      n_r    <= fill_cur;
      base_r <= in_base;
      k_r    <= fill_cur;
    end else if (state_r == ST_SHIFT && rdata_r > v_r) begin
      k_r <= k_r - KW'(1);
    end
    if (state_r == ST_WAIT) begin
      out_value_r   <= rdata_r;
      out_final_r   <= (CW'(cnt_r + CW'(1)) == total_r);
      out_dropped_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      eb_r        <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (ins_done) begin
        fill_r[ins_b] <= ins_n;
        total_r       <= total_r + CW'(1);
      end
      if (in_fire && in_drop) begin
        ovf_r <= 1'b1;
      end

      // walk position rests at the first bucket outside emission
      if (state_r == ST_SCAN) begin
        if (!scan_hit && eb_r != BW'(NUM_BUCKETS - 1)) begin
          eb_r <= eb_r + BW'(1);
          j_r  <= '0;
        end
      end else if (state_r == ST_WAIT) begin
        j_r   <= j_r + KW'(1);
        cnt_r <= cnt_r + CW'(1);
      end else begin
        eb_r  <= '0;
        j_r   <= '0;
        cnt_r <= '0;
      end

      if (state_r == ST_WAIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (set_clear) begin
        total_r <= '0;
        ovf_r   <= 1'b0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          fill_r[i] <= '0;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_final_res    = out_final_r;
  assign out_dropped      = out_dropped_r;

  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WAIT))
    else $error("output word loaded outside the read wait");

  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (k_r != '0 && k_r <= n_r))
    else $error("shift position out of bucket range");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ins_done |-> (total_r < CW'(MAX_ITEMS)))
    else $error("insertion past total capacity");

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> (cnt_r < total_r))
    else $error("more results than stored words");

endmodule

// ===== src/bsf_bucket_idx.sv =====
module bsf_bucket_idx
  import bsf_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  localparam int BW = $clog2(NUM_BUCKETS)
) (
  input  logic [VAL_W-1:0] value,
  output logic [VAL_W-1:0] v_sat,
  output logic [BW-1:0]    bucket
);

  localparam int PW = VAL_W + $clog2(NUM_BUCKETS) + 1;
  localparam int HW = PW - FRAC_W;

  logic [PW-1:0] prod;
  logic [HW-1:0] hi;

  // saturate above one, then scale by the bucket count
  assign v_sat = (value > ONE_Q16) ? ONE_Q16 : value;
  assign prod  = PW'(v_sat) * PW'(NUM_BUCKETS);
  assign hi    = prod[PW-1:FRAC_W];

  // exactly one lands past the top bucket: clamp it back
  assign bucket = (hi >= HW'(NUM_BUCKETS)) ? BW'(NUM_BUCKETS - 1) : hi[BW-1:0];

endmodule

// ===== tb/sv/bucket_sort_fraction_core_test.sv =====
module bucket_sort_fraction_core_test;
  import bsf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_WORDS   = 38;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             final_res;
    logic             dropped;
  } sorted_word_t;

  class fraction_sort_board;
    logic [VAL_W-1:0] bucket_vals [NUM_BUCKETS_DEF][BUCKET_DEPTH_DEF];
    int unsigned      bucket_fill [NUM_BUCKETS_DEF];
    int unsigned      stored_total;
    bit               overflow_seen;
    sorted_word_t     pending_sorted [$];
    int unsigned      failures;
    int unsigned      fractions_noted;
    int unsigned      words_checked;
    int unsigned      sets_closed;
    int unsigned      sets_dropped;

    function void note_fraction(logic [VAL_W-1:0] raw, bit is_last);
      logic [VAL_W-1:0] v;
      int               b;
      int               pos;
      int unsigned      emitted;
      sorted_word_t     w;
      v = (raw > ONE_Q16) ? ONE_Q16 : raw;
      b = (int'(v) * NUM_BUCKETS_DEF) >> FRAC_W;
      if (b >= NUM_BUCKETS_DEF) b = NUM_BUCKETS_DEF - 1;
      fractions_noted++;
      if (bucket_fill[b] >= BUCKET_DEPTH_DEF || stored_total >= MAX_ITEMS_DEF) begin
        overflow_seen = 1'b1;
      end else begin
        // shift larger entries up; equal ones stay ahead of the new word
        pos = bucket_fill[b];
        while (pos > 0 && bucket_vals[b][pos-1] > v) begin
          bucket_vals[b][pos] = bucket_vals[b][pos-1];
          pos--;
        end
        bucket_vals[b][pos] = v;
        bucket_fill[b]++;
        stored_total++;
      end
      if (!is_last) return;
      emitted = 0;
      for (int i = 0; i < NUM_BUCKETS_DEF; i++) begin
        for (int j = 0; j < bucket_fill[i]; j++) begin
          w.value     = bucket_vals[i][j];
          w.final_res = (emitted == stored_total - 1);
          w.dropped   = overflow_seen;
          pending_sorted.push_back(w);
          emitted++;
        end
      end
      sets_closed++;
      if (overflow_seen) sets_dropped++;
      foreach (bucket_fill[i]) bucket_fill[i] = 0;
      stored_total  = 0;
      overflow_seen = 1'b0;
    endfunction

    function void check_sorted(logic [VAL_W-1:0] value, logic final_res, logic dropped);
      sorted_word_t w;
      if (pending_sorted.size() == 0) begin
        $error("unexpected sorted word: sorted_value %0d final_res %0d dropped %0d",
               value, final_res, dropped);
        failures++;
        return;
      end
      w = pending_sorted.pop_front();
      words_checked++;
      if (value !== w.value) begin
        $error("sorted_value: expected %0d, got %0d", w.value, value);
        failures++;
      end
      if (final_res !== w.final_res) begin
        $error("final_res: expected %0d, got %0d", w.final_res, final_res);
        failures++;
      end
      if (dropped !== w.dropped) begin
        $error("dropped: expected %0d, got %0d", w.dropped, dropped);
        failures++;
      end
    endfunction

    function void flag_leftovers();
      if (pending_sorted.size() != 0) begin
        $error("%0d sorted words never arrived", pending_sorted.size());
        failures++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] in_value = '0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] out_sorted_value;
  logic             out_final_res;
  logic             out_dropped;

  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_cycles = 0;
  int unsigned        cycle_count = 0;
  fraction_sort_board board;

  bucket_sort_fraction_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_dropped      (out_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: a pending hold-off wins over random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_sorted(out_sorted_value, out_final_res, out_dropped);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles", cycle_count);
    $display("bucket_sort_fraction_core_test: FAIL");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_in_bucket(int b);
    int unsigned lo;
    int unsigned hi;
    lo = (b * 65536 + NUM_BUCKETS_DEF - 1) / NUM_BUCKETS_DEF;
    hi = ((b + 1) * 65536 + NUM_BUCKETS_DEF - 1) / NUM_BUCKETS_DEF - 1;
    return VAL_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [VAL_W-1:0] pick_fraction();
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(99);
    if (roll < 6) return ONE_Q16;
    if (roll < 14) return VAL_W'($urandom_range(131071, 65537));
    if (roll < 24) begin
      // land on either side of a bucket boundary
      k = $urandom_range(NUM_BUCKETS_DEF - 1, 1);
      return VAL_W'((k * 65536 + NUM_BUCKETS_DEF - 1) / NUM_BUCKETS_DEF
                    - $urandom_range(1, 0));
    end
    return VAL_W'($urandom_range(65535, 0));
  endfunction

  task automatic send_fraction(input logic [VAL_W-1:0] v, input bit is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_fraction(v, is_last);
  endtask

  // cluster < 0 spreads the words over all buckets
  task automatic send_set(input int count, input int cluster);
    logic [VAL_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      v = (cluster < 0) ? pick_fraction() : pick_in_bucket(cluster);
      send_fraction(v, i == count - 1);
    end
  endtask

  task automatic release_and_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int          sent;
    int unsigned roll;
    int          size;
    sent = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < PHASE_WORDS) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        size = $urandom_range(12, 1);
        send_set(size, -1);
      end else if (roll < 85) begin
        // crowd one bucket, often past its depth
        size = $urandom_range(20, 12);
        send_set(size, $urandom_range(NUM_BUCKETS_DEF - 1, 0));
      end else begin
        // often run past total capacity
        size = $urandom_range(70, 58);
        send_set(size, -1);
      end
      sent += size;
    end
    release_and_drain();
  endtask

  initial begin
    logic [VAL_W-1:0] opening [9];
    opening = '{17'd0, 17'h1FFFF, ONE_Q16, 17'd6553, 17'd6554,
                17'd39000, 17'd30000, 17'd37000, 17'd30000};
    board = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // extremes, saturation, boundaries, head insert, equal words
    for (int i = 0; i < 9; i++) send_fraction(opening[i], i == 8);
    send_fraction(ONE_Q16, 1'b1);
    // overfill one bucket; the last word itself is dropped
    send_set(BUCKET_DEPTH_DEF + 1, 3);
    release_and_drain();

    // hold the output long enough for the core to back up into its input
    hold_cycles = 300;
    send_set(10, -1);
    send_set(9, -1);
    release_and_drain();

    run_random_phase(0, 0);
    run_random_phase(67, 0);
    run_random_phase(0, 67);
    run_random_phase(19, 19);

    board.flag_leftovers();
    $display("%0d fractions in %0d sets sorted, %0d sets with dropped words",
             board.fractions_noted, board.sets_closed, board.sets_dropped);
    $display("%0d result words checked under mixed idle and stall pressure",
             board.words_checked);
    if (board.failures == 0)
      $display("bucket_sort_fraction_core_test: PASS");
    else
      $display("bucket_sort_fraction_core_test: FAIL");
    $finish;
  end

endmodule
